FILE: hdl/cdo_pkg.sv
// Shared constants, field widths and calendar tables for the date offset core.
package cdo_pkg;

    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 23;
    localparam int SERIAL_W = 22;

    localparam int MAX_YEAR = 9999;

    // Days in the full years 1..MAX_YEAR; the last serial that is in range.
    localparam int TOP_SERIAL = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

    // Width of a day count over full years of any 14-bit year.
    localparam int DAYS_W = 23;
    // Signed width of a serial plus an offset.
    localparam int SUM_W  = 25;
    // Width of a day of the year.
    localparam int DOY_W  = 9;

    // Quotient by 100 through a reciprocal; exact for every 14-bit year.
    localparam int Q100_SHIFT = 20;
    localparam int Q100_MUL   = (1 << Q100_SHIFT) / 100 + 1;
    localparam int Q100_W     = 8;

    // Year estimate from a serial: times 400 / 146097.
    localparam int          YEAR_SHIFT = 24;
    localparam longint      YEAR_MUL   = (64'd400 << YEAR_SHIFT) / 64'd146097;
    localparam int          YMUL_W     = 16;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic lp);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                                   len = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] cum_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/cdo_req_if.sv
// Request channel: input date and day offset with a valid/ready handshake.
interface cdo_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [cdo_pkg::MONTH_W-1:0]     month_in;
    logic        [cdo_pkg::DAY_W-1:0]       day_in;
    logic        [cdo_pkg::YEAR_W-1:0]      year_in;
    logic signed [cdo_pkg::OFFSET_W-1:0]    day_offset;

    modport source (output valid, month_in, day_in, year_in, day_offset, input ready);
    modport sink   (input valid, month_in, day_in, year_in, day_offset, output ready);
endinterface

FILE: hdl/cdo_rsp_if.sv
// Response channel: result date, serial and valid flag with a valid/ready handshake.
interface cdo_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               valid_res;
    logic [cdo_pkg::MONTH_W-1:0]        month_out;
    logic [cdo_pkg::DAY_W-1:0]          day_out;
    logic [cdo_pkg::YEAR_W-1:0]         year_out;
    logic [cdo_pkg::SERIAL_W-1:0]       serial_out;

    modport source (output valid, valid_res, month_out, day_out, year_out, serial_out,
                    input ready);
    modport sink   (input valid, valid_res, month_out, day_out, year_out, serial_out,
                    output ready);
endinterface

FILE: hdl/calendar_date_day_offset_core.sv
// Top level of the Gregorian date plus day offset core.
//
//  Channel | Direction | Payload                                             | Transfer
//  req     | in        | month_in, day_in, year_in, day_offset               | valid & ready
//  rsp     | out       | valid_res, month_out, day_out, year_out, serial_out | valid & ready
//
// An invalid date is answered after the date check in S_LP0 and S_LP1, a sum out of range
// after the serial states S_FW0 to S_FW3. A valid result also passes S_EST, the downward
// and upward year correction passes through the shared year-days unit (S_DN0, S_DN1 and
// S_UP0, S_UP1) and the month scan in S_MS, which steps one month at a time.
// Ready stays low from a transfer on req until the response has transferred on rsp, and a
// stall on rsp holds the response unchanged. Reset clears only the sequencer state.
module calendar_date_day_offset_core (
    input  logic        clk,
    input  logic        rst_n,
    cdo_req_if.sink     req,
    cdo_rsp_if.source   rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LP0  = 4'd1;
    localparam logic [3:0] S_LP1  = 4'd2;
    localparam logic [3:0] S_FW0  = 4'd3;
    localparam logic [3:0] S_FW1  = 4'd4;
    localparam logic [3:0] S_FW2  = 4'd5;
    localparam logic [3:0] S_FW3  = 4'd6;
    localparam logic [3:0] S_EST  = 4'd7;
    localparam logic [3:0] S_DN0  = 4'd8;
    localparam logic [3:0] S_DN1  = 4'd9;
    localparam logic [3:0] S_UP0  = 4'd10;
    localparam logic [3:0] S_UP1  = 4'd11;
    localparam logic [3:0] S_MS   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam int MW = cdo_pkg::MONTH_W;
    localparam int DW = cdo_pkg::DAY_W;
    localparam int YW = cdo_pkg::YEAR_W;
    localparam int OW = cdo_pkg::OFFSET_W;
    localparam int SW = cdo_pkg::SERIAL_W;
    localparam int NW = cdo_pkg::DAYS_W;
    localparam int UW = cdo_pkg::SUM_W;
    localparam int RW = cdo_pkg::DOY_W;
    localparam int QW = cdo_pkg::Q100_W;

    logic [3:0]            state_reg, state_next;

    logic [MW-1:0]         m_reg, m_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [YW-1:0]         y_reg, y_next;
    logic signed [OW-1:0]  off_reg, off_next;
    logic                  leap_reg, leap_next;
    logic [YW-1:0]         arg_reg, arg_next;
    logic signed [UW-1:0]  s_reg, s_next;
    logic [YW-1:0]         yc_reg, yc_next;
    logic [NW-1:0]         dblo_reg, dblo_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [MW-1:0]         mc_reg, mc_next;

    logic                  res_valid_reg, res_valid_next;
    logic [MW-1:0]         res_month_reg, res_month_next;
    logic [DW-1:0]         res_day_reg, res_day_next;
    logic [YW-1:0]         res_year_reg, res_year_next;
    logic [SW-1:0]         res_serial_reg, res_serial_next;

    // Shared year-days unit: the products are registered, then added and compared.
    logic [QW-1:0]         q_reg;
    logic [NW-1:0]         m365_reg;
    logic [2*YW-1:0]       q_prod;
    logic [NW-1:0]         db_comb;
    logic [YW:0]           q_times100;
    logic                  leap_comb;

    logic [SW-1:0]         sm1;
    logic [SW+cdo_pkg::YMUL_W-1:0] y_prod;
    logic [DW-1:0]         len_in;
    logic                  date_ok;
    logic [RW-1:0]         ms_before;
    logic [RW-1:0]         ms_end;

    assign q_prod     = (2*YW)'(arg_reg) * (2*YW)'(cdo_pkg::Q100_MUL);
    assign db_comb    = m365_reg + NW'(arg_reg >> 2) - NW'(q_reg) + NW'(q_reg >> 2);
    assign q_times100 = (YW+1)'(q_reg) * (YW+1)'(100);
    assign leap_comb  = (arg_reg[1:0] == 2'b00)
                        && ((q_times100 != (YW+1)'(arg_reg)) || (q_reg[1:0] == 2'b00));

    always_ff @(posedge clk)
    begin
        q_reg    <= q_prod[cdo_pkg::Q100_SHIFT +: QW];
        m365_reg <= NW'(NW'(arg_reg) * NW'(365));
    end

    assign sm1    = s_reg[SW-1:0] - SW'(1);
    assign y_prod = (SW+cdo_pkg::YMUL_W)'(sm1)
                    * (SW+cdo_pkg::YMUL_W)'(cdo_pkg::YEAR_MUL);

    assign len_in  = cdo_pkg::month_len(m_reg, leap_comb);
    assign date_ok = (m_reg >= MW'(1)) && (m_reg <= MW'(12)) && (d_reg != '0)
                     && (y_reg != '0) && (d_reg <= len_in);

    assign ms_before = cdo_pkg::cum_before(mc_reg)
                       + RW'(leap_reg && (mc_reg > MW'(2)));
    assign ms_end    = ms_before + RW'(cdo_pkg::month_len(mc_reg, leap_reg));

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = (state_reg == S_OUT);
    assign rsp.valid_res = res_valid_reg;
    assign rsp.month_out = res_month_reg;
    assign rsp.day_out   = res_day_reg;
    assign rsp.year_out  = res_year_reg;
    assign rsp.serial_out = res_serial_reg;

    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        d_next          = d_reg;
        y_next          = y_reg;
        off_next        = off_reg;
        leap_next       = leap_reg;
        arg_next        = arg_reg;
        s_next          = s_reg;
        yc_next         = yc_reg;
        dblo_next       = dblo_reg;
        r_next          = r_reg;
        mc_next         = mc_reg;
        res_valid_next  = res_valid_reg;
        res_month_next  = res_month_reg;
        res_day_next    = res_day_reg;
        res_year_next   = res_year_reg;
        res_serial_next = res_serial_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    m_next     = req.month_in;
                    d_next     = req.day_in;
                    y_next     = req.year_in;
                    off_next   = req.day_offset;
                    arg_next   = req.year_in;
                    state_next = S_LP0;
                end
            end
            S_LP0:
            begin
                state_next = S_LP1;
            end
            S_LP1:
            begin
                if (!date_ok)
                begin
                    res_valid_next  = 1'b0;
                    res_month_next  = '0;
                    res_day_next    = '0;
                    res_year_next   = '0;
                    res_serial_next = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    leap_next  = leap_comb;
                    arg_next   = y_reg - YW'(1);
                    state_next = S_FW0;
                end
            end
            S_FW0:
            begin
                state_next = S_FW1;
            end
            S_FW1:
            begin
                s_next     = $signed(UW'(db_comb) + UW'(d_reg)
                                     + UW'(cdo_pkg::cum_before(m_reg)));
                state_next = S_FW2;
            end
            S_FW2:
            begin
                s_next     = s_reg + UW'(off_reg) + UW'(leap_reg && (m_reg > MW'(2)));
                state_next = S_FW3;
            end
            S_FW3:
            begin
                if ((s_reg < UW'(1)) || (s_reg > $signed(UW'(cdo_pkg::TOP_SERIAL))))
                begin
                    res_valid_next  = 1'b0;
                    res_month_next  = '0;
                    res_day_next    = '0;
                    res_year_next   = '0;
                    res_serial_next = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_EST;
                end
            end
            S_EST:
            begin
                yc_next    = y_prod[cdo_pkg::YEAR_SHIFT +: YW];
                arg_next   = y_prod[cdo_pkg::YEAR_SHIFT +: YW];
                state_next = S_DN0;
            end
            S_DN0:
            begin
                state_next = S_DN1;
            end
            S_DN1:
            begin
                if ((yc_reg != '0) && (db_comb >= s_reg[NW-1:0]))
                begin
                    yc_next    = yc_reg - YW'(1);
                    arg_next   = yc_reg - YW'(1);
                    state_next = S_DN0;
                end
                else
                begin
                    dblo_next  = db_comb;
                    arg_next   = yc_reg + YW'(1);
                    state_next = S_UP0;
                end
            end
            S_UP0:
            begin
                state_next = S_UP1;
            end
            S_UP1:
            begin
                if (db_comb < s_reg[NW-1:0])
                begin
                    yc_next    = yc_reg + YW'(1);
                    dblo_next  = db_comb;
                    arg_next   = yc_reg + YW'(2);
                    state_next = S_UP0;
                end
                else
                begin
                    leap_next  = leap_comb;
                    r_next     = RW'(s_reg[NW-1:0] - dblo_reg);
                    mc_next    = MW'(1);
                    state_next = S_MS;
                end
            end
            S_MS:
            begin
                if ((r_reg <= ms_end) || (mc_reg == MW'(12)))
                begin
                    res_valid_next  = 1'b1;
                    res_month_next  = mc_reg;
                    res_day_next    = DW'(r_reg - ms_before);
                    res_year_next   = yc_reg + YW'(1);
                    res_serial_next = s_reg[SW-1:0];
                    state_next      = S_OUT;
                end
                else
                begin
                    mc_next = mc_reg + MW'(1);
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        d_reg          <= d_next;
        y_reg          <= y_next;
        off_reg        <= off_next;
        leap_reg       <= leap_next;
        arg_reg        <= arg_next;
        s_reg          <= s_next;
        yc_reg         <= yc_next;
        dblo_reg       <= dblo_next;
        r_reg          <= r_next;
        mc_reg         <= mc_next;
        res_valid_reg  <= res_valid_next;
        res_month_reg  <= res_month_next;
        res_day_reg    <= res_day_next;
        res_year_reg   <= res_year_next;
        res_serial_reg <= res_serial_next;
    end

endmodule

FILE: hdl/cdo_checker.sv
// Port-level assertions for the date offset core and the bind that attaches them.
module cdo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          valid_res,
    input logic [cdo_pkg::MONTH_W-1:0]   month_out,
    input logic [cdo_pkg::DAY_W-1:0]     day_out,
    input logic [cdo_pkg::YEAR_W-1:0]    year_out,
    input logic [cdo_pkg::SERIAL_W-1:0]  serial_out
);

    // The core works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request accepted while a response is pending");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
        else $error("core not busy after a request transfer");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !valid_res) |-> ((month_out == '0) && (day_out == '0)
                                       && (year_out == '0) && (serial_out == '0)))
        else $error("invalid response carries nonzero fields");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && valid_res) |-> ((month_out >= 4'd1) && (month_out <= 4'd12)
            && (day_out != '0) && (year_out != '0)
            && (year_out <= cdo_pkg::YEAR_W'(cdo_pkg::MAX_YEAR)) && (serial_out != '0)))
        else $error("valid response out of range");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(serial_out) && $stable(valid_res)))
        else $error("stalled response changed");

endmodule

bind calendar_date_day_offset_core cdo_checker u_cdo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .valid_res  (rsp.valid_res),
    .month_out  (rsp.month_out),
    .day_out    (rsp.day_out),
    .year_out   (rsp.year_out),
    .serial_out (rsp.serial_out)
);

FILE: dv/tb_calendar_date_day_offset_core.sv
// Testbench for the date offset core: directed and random dates checked against a calendar.
`timescale 1ns / 100ps

module tb_calendar_date_day_offset_core;

    localparam int MW              = cdo_pkg::MONTH_W;
    localparam int DW              = cdo_pkg::DAY_W;
    localparam int YW              = cdo_pkg::YEAR_W;
    localparam int OW              = cdo_pkg::OFFSET_W;
    localparam int SW              = cdo_pkg::SERIAL_W;
    localparam int OFFSET_MIN      = -(1 << (OW - 1));
    localparam int OFFSET_MAX      = (1 << (OW - 1)) - 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_ITEMS    = 400;

    typedef struct {
        logic        [MW-1:0] month;
        logic        [DW-1:0] day;
        logic        [YW-1:0] year;
        logic signed [OW-1:0] offset;
    } date_query_t;

    typedef struct {
        logic          valid_res;
        logic [MW-1:0] month;
        logic [DW-1:0] day;
        logic [YW-1:0] year;
        logic [SW-1:0] serial;
    } date_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    cdo_req_if req_ch ();
    cdo_rsp_if rsp_ch ();

    calendar_date_day_offset_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    date_answer_t pending_dates[$];
    int error_count   = 0;
    int valid_seen    = 0;
    int rejected_seen = 0;
    int stall_pct     = 0;
    int hold_off_req  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    bit sender_gaps   = 1'b0;
    int burst_left    = 0;

    always #4 clk = ~clk;

    function automatic bit is_leap(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint month_days(input longint m, input longint y);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2)
            return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic longint days_through(input longint y);
        if (y <= 0)
            return 0;
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    function automatic date_answer_t shift_date(input date_query_t q);
        date_answer_t a;
        longint       m;
        longint       d;
        longint       y;
        longint       s;
        longint       yc;
        longint       rem;
        longint       cum;
        longint       i;
        a.valid_res = 1'b0;
        a.month     = '0;
        a.day       = '0;
        a.year      = '0;
        a.serial    = '0;
        m = longint'(q.month);
        d = longint'(q.day);
        y = longint'(q.year);
        if (m < 1 || m > 12 || d < 1 || y < 1 || d > month_days(m, y))
            return a;
        s = days_through(y - 1) + d;
        for (i = 1; i < m; i++)
            s += month_days(i, y);
        s += longint'(q.offset);
        if (s < 1 || s > days_through(cdo_pkg::MAX_YEAR))
            return a;
        yc = ((s - 1) * 400) / 146097;
        while (yc > 0 && days_through(yc) >= s)
            yc--;
        while (days_through(yc + 1) < s)
            yc++;
        y   = yc + 1;
        rem = s - days_through(yc);
        cum = 0;
        m   = 1;
        while (rem > cum + month_days(m, y))
        begin
            cum += month_days(m, y);
            m++;
        end
        a.valid_res = 1'b1;
        a.month     = MW'(m);
        a.day       = DW'(rem - cum);
        a.year      = YW'(y);
        a.serial    = SW'(s);
        return a;
    endfunction

    function automatic date_query_t random_query();
        date_query_t q;
        int          pick;
        longint      last_day;
        q.month  = MW'($urandom);
        q.day    = DW'($urandom);
        q.year   = YW'($urandom);
        q.offset = OW'($urandom);
        pick = $urandom_range(99);
        if (pick >= 10)
        begin
            if (pick < 18)
                q.year = YW'($urandom_range(16383, cdo_pkg::MAX_YEAR + 1));
            else if (pick < 30)
                q.year = YW'($urandom_range(400, 1));
            else
                q.year = YW'($urandom_range(cdo_pkg::MAX_YEAR, 1));
            q.month  = MW'($urandom_range(12, 1));
            last_day = month_days(longint'(q.month), longint'(q.year));
            if ($urandom_range(3) == 0)
                q.day = DW'(last_day);
            else
                q.day = DW'($urandom_range(int'(last_day), 1));
            case ($urandom_range(3))
                0:       q.offset = OW'(int'($urandom_range(80)) - 40);
                1:       q.offset = OW'(int'($urandom_range(3000)) - 1500);
                2:       q.offset = OW'(int'($urandom_range(2000000)) - 1000000);
                default: q.offset = OW'($urandom);
            endcase
        end
        return q;
    endfunction

    function automatic void check_field(input string name, input logic [SW-1:0] expv,
                                        input logic [SW-1:0] act);
        if (act !== expv)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
            error_count++;
        end
    endfunction

    task automatic send_query(input date_query_t q);
        req_ch.valid      <= 1'b1;
        req_ch.month_in   <= q.month;
        req_ch.day_in     <= q.day;
        req_ch.year_in    <= q.year;
        req_ch.day_offset <= q.offset;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_dates.push_back(shift_date(q));
    endtask

    task automatic send_fields(input int m, input int d, input int y, input int off);
        date_query_t q;
        q.month  = MW'(m);
        q.day    = DW'(d);
        q.year   = YW'(y);
        q.offset = OW'(off);
        send_query(q);
    endtask

    task automatic test_invalid_dates();
        send_fields(0, 1, 2000, 0);
        send_fields(13, 1, 2000, 0);
        send_fields(15, 31, 16383, OFFSET_MAX);
        send_fields(1, 0, 2000, 0);
        send_fields(4, 31, 2023, 0);
        send_fields(2, 29, 1900, 0);
        send_fields(2, 30, 2000, 5);
        send_fields(1, 1, 0, 0);
    endtask

    task automatic test_calendar_corners();
        send_fields(2, 29, 2000, 0);
        send_fields(1, 1, 1, 0);
        send_fields(1, 1, 1, -1);
        send_fields(12, 31, cdo_pkg::MAX_YEAR, 0);
        send_fields(12, 31, cdo_pkg::MAX_YEAR, 1);
        send_fields(1, 1, 1, cdo_pkg::TOP_SERIAL - 1);
        send_fields(1, 1, 1, OFFSET_MAX);
        send_fields(1, 1, 16383, OFFSET_MIN);
        send_fields(12, 31, 16383, OFFSET_MIN);
        send_fields(1, 1, 16383, -1);
        send_fields(1, 31, 2023, 28);
        send_fields(3, 1, 2024, -1);
        send_fields(3, 1, 2100, -1);
        send_fields(12, 30, 2023, 1);
        send_fields(1, 1, 2000, -1);
        send_fields(6, 15, 5000, OFFSET_MIN);
        send_fields(12, 31, 1600, 0);
    endtask

    task automatic test_random_traffic();
        int i;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                sender_gaps = bit'((i / 100) % 2);
                stall_pct  <= (i / 100 < 2) ? 0 : 20 + 20 * ((i / 100) % 2);
            end
            if (sender_gaps)
            begin
                if (burst_left == 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat ($urandom_range(6, 1)) @(posedge clk);
                    burst_left = $urandom_range(10, 1);
                end
                burst_left--;
            end
            send_query(random_query());
        end
    endtask

    task automatic test_backpressure();
        int i;
        stall_pct    <= 20;
        hold_off_req <= hold_off_req + 1;
        for (i = 0; i < 12; i++)
            send_query(random_query());
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_off_req)
        begin
            hold_seen    <= hold_off_req;
            hold_left    <= HOLD_OFF_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        date_answer_t exp_a;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %0d-%0d-%0d",
                         $time, rsp_ch.year_out, rsp_ch.month_out, rsp_ch.day_out);
                error_count++;
            end
            else
            begin
                exp_a = pending_dates.pop_front();
                check_field("valid_res", SW'(exp_a.valid_res), SW'(rsp_ch.valid_res));
                check_field("month_out", SW'(exp_a.month), SW'(rsp_ch.month_out));
                check_field("day_out", SW'(exp_a.day), SW'(rsp_ch.day_out));
                check_field("year_out", SW'(exp_a.year), SW'(rsp_ch.year_out));
                check_field("serial_out", exp_a.serial, rsp_ch.serial_out);
                if (exp_a.valid_res)
                    valid_seen++;
                else
                    rejected_seen++;
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.month_in   <= '0;
        req_ch.day_in     <= '0;
        req_ch.year_in    <= '0;
        req_ch.day_offset <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_invalid_dates();
        test_calendar_corners();
        test_random_traffic();
        test_backpressure();
        req_ch.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results: %0d valid dates, %0d rejected or out of range.",
                 valid_seen + rejected_seen, valid_seen, rejected_seen);
        $display("Covered corner dates, random traffic with gaps and stalls, %s %0d cycles.",
                 "and a receiver hold-off of", HOLD_OFF_CYCLES);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout waiting for the core.");
        $display("Test completed with failures");
        $finish;
    end

endmodule
